FILE: rtl/core/r2y_pkg.sv
// ----------------------------------------------------------------------------
// r2y_pkg: shared definitions for the RGB to YCbCr 4:2:0 flip and crop block
// Holds the field widths, the configuration register indexes and defaults,
// the BT.601 coefficients and the helpers that clamp the frame dimensions.
// ----------------------------------------------------------------------------
package r2y_pkg;

   localparam int MAX_DIM     = 2048;
   localparam int CFG_W       = 12;
   localparam int DIM_W       = 11;
   localparam int PIX_W       = 8;
   localparam int LUMA_IDX_W  = 22;
   localparam int CHROMA_IDX_W = 20;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_WIDTH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_HEIGHT   = 2'd3;

   localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

   // Coefficient magnitudes; the signs are applied where the sums are formed.
   localparam int COEF_Y_R = 66;
   localparam int COEF_Y_G = 129;
   localparam int COEF_Y_B = 25;
   localparam int COEF_U_R = 38;
   localparam int COEF_U_G = 74;
   localparam int COEF_U_B = 112;
   localparam int COEF_V_R = 112;
   localparam int COEF_V_G = 94;
   localparam int COEF_V_B = 18;
   localparam int ROUND    = 128;
   localparam int LUMA_BIAS = 16;
   // Rounding term plus the chroma offset of 128 scaled by 256.
   localparam int CHROMA_OFFSET = 32896;

   // Pixel held between the input register and the result register.
   typedef struct packed {
      logic             keep;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [DIM_W-1:0] column;
      logic [DIM_W-1:0] out_row;
   } pixel_type;

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > CFG_W'(MAX_DIM)) begin
         r = CFG_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [CFG_W-1:0] min_dim(input logic [CFG_W-1:0] a,
                                                input logic [CFG_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

FILE: rtl/core/rgba_to_yuv420_flip_crop.sv
// ----------------------------------------------------------------------------
// rgba_to_yuv420_flip_crop: streaming RGB to BT.601 YCbCr 4:2:0 converter
// Locates each source pixel with column and row counters, flips the image
// vertically, crops it to the encoder size and emits luma and chroma samples
// with their plane offsets.
// ----------------------------------------------------------------------------
// A kept item passes from the edge that accepts it into the input register, then into
// the result register, whose contents are shown on the result port.
// Throughput: one item per cycle, sustained while the result side takes items.
// Pixels outside the crop window pass through the input register and give no result.
// Reset (synchronous, active high) clears the counters and both valid flags and
// restores the registers to a 640 x 480 source with a 640 x 480 crop.

module rgba_to_yuv420_flip_crop
   import r2y_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_data,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [PIX_W-1:0]        req_red,
   input  logic [PIX_W-1:0]        req_green,
   input  logic [PIX_W-1:0]        req_blue,
   input  logic                    req_frame_start,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [PIX_W-1:0]        rsp_luma,
   output logic [LUMA_IDX_W-1:0]   rsp_luma_index,
   output logic                    rsp_chroma_valid,
   output logic [PIX_W-1:0]        rsp_chroma_u,
   output logic [PIX_W-1:0]        rsp_chroma_v,
   output logic [CHROMA_IDX_W-1:0] rsp_chroma_index,
   output logic                    rsp_frame_done
);

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are always taken; the user must make them only
   // while no item is in flight (not enforced here), so both stages read them freely.
   // ---------------------------------------------------------------------
   logic [CFG_W-1:0] src_w_ff, src_h_ff, crop_w_ff, crop_h_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff  <= RESET_WIDTH;
         src_h_ff  <= RESET_HEIGHT;
         crop_w_ff <= RESET_WIDTH;
         crop_h_ff <= RESET_HEIGHT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_ff  <= csr_data;
            CSR_SOURCE_HEIGHT: src_h_ff  <= csr_data;
            CSR_CROP_WIDTH:    crop_w_ff <= csr_data;
            CSR_CROP_HEIGHT:   crop_h_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Effective sizes: a zero source size counts as one, oversize saturates,
   // and the crop never exceeds the source.
   logic [CFG_W-1:0] sw, sh, cw, ch;

   assign sw = clamp_dim(src_w_ff);
   assign sh = clamp_dim(src_h_ff);
   assign cw = min_dim(crop_w_ff, sw);
   assign ch = min_dim(crop_h_ff, sh);

   // ---------------------------------------------------------------------
   // Pipeline control. Both stages move together whenever the result
   // register is empty or its item is being taken. An item in the input
   // register that lies outside the crop simply leaves with no result.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic accept;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Pixel location at acceptance. The frame start mark clears the counters
   // before the pixel is placed, and counters left beyond a smaller frame
   // size fall back to zero.
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] col_cur, row_cur;
   logic [CFG_W-1:0] col_next, row_next;
   logic [CFG_W:0]   row_plus_ch;
   logic [CFG_W-1:0] out_row_full;
   pixel_type        s1_ff, s1_in;

   always_comb begin
      if (req_frame_start || ({1'b0, col_ff} >= sw)) begin
         col_cur = '0;
      end else begin
         col_cur = col_ff;
      end
      if (req_frame_start || ({1'b0, row_ff} >= sh)) begin
         row_cur = '0;
      end else begin
         row_cur = row_ff;
      end

      // The kept window is the top of the flipped image, which is the last
      // crop-height rows of the source.
      row_plus_ch  = {2'b00, row_cur} + {1'b0, ch};
      out_row_full = sh - CFG_W'(1) - {1'b0, row_cur};

      s1_in.keep    = ({1'b0, col_cur} < cw) && (row_plus_ch >= {1'b0, sh});
      s1_in.red     = req_red;
      s1_in.green   = req_green;
      s1_in.blue    = req_blue;
      s1_in.column  = col_cur;
      s1_in.out_row = out_row_full[DIM_W-1:0];

      // Step to the next pixel position, wrapping at the row and frame ends.
      col_next = {1'b0, col_cur} + CFG_W'(1);
      row_next = {1'b0, row_cur} + CFG_W'(1);
      if (col_next >= sw) begin
         col_in = '0;
         if (row_next >= sh) begin
            row_in = '0;
         end else begin
            row_in = row_next[DIM_W-1:0];
         end
      end else begin
         col_in = col_next[DIM_W-1:0];
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Colour conversion and plane offsets. Every sum is bounded so that the
   // biased chroma lies in 16..240 and luma in 16..235: the clamp to a byte
   // can never act, and the bytes are taken straight from the shifted sums.
   // The chroma sums stay non-negative once the offset is added, so plain
   // unsigned arithmetic gives the floor shift.
   // ---------------------------------------------------------------------
   logic [16:0] luma_sum, u_sum, v_sum;
   logic [PIX_W-1:0] luma_val;
   logic [22:0] luma_prod;
   logic [20:0] chroma_prod;
   logic [21:0] chroma_idx_full;
   logic        chroma_on;
   logic        done_val;
   logic [PIX_W-1:0] luma_ff, u_ff, v_ff;
   logic [LUMA_IDX_W-1:0] luma_idx_ff;
   logic [CHROMA_IDX_W-1:0] chroma_idx_ff;
   logic chroma_valid_ff, frame_done_ff;

   always_comb begin
      luma_sum = 17'(COEF_Y_R) * 17'(s1_ff.red)
               + 17'(COEF_Y_G) * 17'(s1_ff.green)
               + 17'(COEF_Y_B) * 17'(s1_ff.blue)
               + 17'(ROUND);
      u_sum    = 17'(CHROMA_OFFSET)
               + 17'(COEF_U_B) * 17'(s1_ff.blue)
               - 17'(COEF_U_R) * 17'(s1_ff.red)
               - 17'(COEF_U_G) * 17'(s1_ff.green);
      v_sum    = 17'(CHROMA_OFFSET)
               + 17'(COEF_V_R) * 17'(s1_ff.red)
               - 17'(COEF_V_G) * 17'(s1_ff.green)
               - 17'(COEF_V_B) * 17'(s1_ff.blue);
      luma_val = luma_sum[15:8] + PIX_W'(LUMA_BIAS);

      luma_prod       = 23'(s1_ff.out_row) * 23'(cw);
      chroma_prod     = 21'(s1_ff.out_row[DIM_W-1:1]) * 21'(cw[CFG_W-1:1]);
      chroma_idx_full = 22'(chroma_prod) + 22'(s1_ff.column[DIM_W-1:1]);
      chroma_on       = !s1_ff.out_row[0] && !s1_ff.column[0];
      done_val        = (s1_ff.out_row == '0) && ({1'b0, s1_ff.column} == cw - CFG_W'(1));
   end

   assign rsp_valid_in = advance ? (s1_valid_ff && s1_ff.keep) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         luma_ff         <= luma_val;
         luma_idx_ff     <= luma_prod[LUMA_IDX_W-1:0] + LUMA_IDX_W'(s1_ff.column);
         chroma_valid_ff <= chroma_on;
         u_ff            <= chroma_on ? u_sum[15:8] : '0;
         v_ff            <= chroma_on ? v_sum[15:8] : '0;
         chroma_idx_ff   <= chroma_on ? chroma_idx_full[CHROMA_IDX_W-1:0] : '0;
         frame_done_ff   <= done_val;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_luma         = luma_ff;
   assign rsp_luma_index   = luma_idx_ff;
   assign rsp_chroma_valid = chroma_valid_ff;
   assign rsp_chroma_u     = u_ff;
   assign rsp_chroma_v     = v_ff;
   assign rsp_chroma_index = chroma_idx_ff;
   assign rsp_frame_done   = frame_done_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_ff))
      else $error("input register changed during a stall");

   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (luma_ff >= 8'd16) && (luma_ff <= 8'd235))
      else $error("luma outside the limited range");

   a_chroma_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !chroma_valid_ff |-> (u_ff == '0) && (v_ff == '0)
                                           && (chroma_idx_ff == '0))
      else $error("chroma fields not cleared on a luma-only item");

   a_chroma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && chroma_valid_ff |-> (u_ff >= 8'd16) && (u_ff <= 8'd240)
                                          && (v_ff >= 8'd16) && (v_ff <= 8'd240))
      else $error("chroma outside its reachable range");

endmodule

FILE: tb/sv/rgba_to_yuv420_flip_crop_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_to_yuv420_flip_crop_tb: self-checking bench for the YCbCr 4:2:0 converter
// Streams RGB pixels through the flip and crop window under a range of frame
// settings and idle patterns, predicts every luma and chroma sample in a
// small tracker class and compares each delivered item field by field.
// ----------------------------------------------------------------------------
module rgba_to_yuv420_flip_crop_tb
   import r2y_pkg::*;
;

   // Cycles without any handshake before the run is declared hung. The longest
   // legitimate quiet stretch is the deliberate receiver hold-off below.
   localparam int WATCHDOG_LIMIT  = 4000;
   // Cycles allowed after the last expected item so that a pixel outside the
   // crop window, which gives no item, has left the two-stage pipeline.
   localparam int SETTLE_CYCLES   = 6;
   // Random pixels on top of the directed part, which sends about a hundred.
   localparam int RANDOM_PIXELS   = 700;
   localparam int HOLD_OFF_CYCLES = 160;

   // Colours for the directed part: black, white, the primaries and their
   // complements, mid grey and a few values one step away from the limits.
   localparam logic [23:0] CORNER_COLOURS [16] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00,
      24'h808080, 24'h010203, 24'hFEFDFC, 24'h7F7F80,
      24'h0000FE, 24'hFF0001, 24'h10EB80, 24'h123456
   };

   // One item as it leaves the result port.
   typedef struct {
      logic [PIX_W-1:0]        luma;
      logic [LUMA_IDX_W-1:0]   luma_index;
      logic                    chroma_valid;
      logic [PIX_W-1:0]        chroma_u;
      logic [PIX_W-1:0]        chroma_v;
      logic [CHROMA_IDX_W-1:0] chroma_index;
      logic                    frame_done;
   } yuv_sample_type;

   // Tracks the frame geometry and the pixel counters alongside the block and
   // keeps the samples that are still owed on the result port.
   class yuv_plane_tracker;
      logic [CFG_W-1:0] source_w;
      logic [CFG_W-1:0] source_h;
      logic [CFG_W-1:0] crop_w;
      logic [CFG_W-1:0] crop_h;
      int unsigned      column;
      int unsigned      source_row;
      yuv_sample_type   owed_samples[$];
      int unsigned      errors;

      function new();
         source_w   = RESET_WIDTH;
         source_h   = RESET_HEIGHT;
         crop_w     = RESET_WIDTH;
         crop_h     = RESET_HEIGHT;
         column     = 0;
         source_row = 0;
         errors     = 0;
      endfunction

      // A zero size behaves as one; anything above the maximum saturates.
      static function int unsigned effective_dim(logic [CFG_W-1:0] v);
         if (v == '0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return v;
      endfunction

      static function logic [PIX_W-1:0] saturate_byte(int v);
         if (v < 0) return '0;
         if (v > 255) return '1;
         return v[PIX_W-1:0];
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_SOURCE_WIDTH:  source_w = data;
            CSR_SOURCE_HEIGHT: source_h = data;
            CSR_CROP_WIDTH:    crop_w   = data;
            CSR_CROP_HEIGHT:   crop_h   = data;
            default: ;
         endcase
      endfunction

      function int unsigned owed();
         return owed_samples.size();
      endfunction

      // Places one accepted pixel and, if it falls inside the flipped crop
      // window, queues the sample it must produce.
      function void note_pixel(logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                               logic [PIX_W-1:0] blue, logic frame_start);
         int unsigned    sw, sh, cw, ch, out_row;
         int             r, g, b;
         yuv_sample_type s;
         sw = effective_dim(source_w);
         sh = effective_dim(source_h);
         cw = (crop_w < sw) ? crop_w : sw;
         ch = (crop_h < sh) ? crop_h : sh;
         r  = red;
         g  = green;
         b  = blue;
         if (frame_start) begin
            column     = 0;
            source_row = 0;
         end
         // A smaller frame written since the last pixel puts the counters
         // back to the origin.
         if (column >= sw) column = 0;
         if (source_row >= sh) source_row = 0;
         if (column < cw && source_row + ch >= sh) begin
            out_row = sh - 1 - source_row;
            s.luma = saturate_byte(((COEF_Y_R * r + COEF_Y_G * g + COEF_Y_B * b + ROUND)
                                    >>> 8) + LUMA_BIAS);
            s.luma_index   = LUMA_IDX_W'(out_row * cw + column);
            s.chroma_valid = (out_row[0] == 1'b0) && (column[0] == 1'b0);
            if (s.chroma_valid) begin
               s.chroma_u = saturate_byte(((-COEF_U_R * r - COEF_U_G * g + COEF_U_B * b
                                            + ROUND) >>> 8) + 128);
               s.chroma_v = saturate_byte(((COEF_V_R * r - COEF_V_G * g - COEF_V_B * b
                                            + ROUND) >>> 8) + 128);
               s.chroma_index = CHROMA_IDX_W'((out_row >> 1) * (cw >> 1) + (column >> 1));
            end else begin
               s.chroma_u     = '0;
               s.chroma_v     = '0;
               s.chroma_index = '0;
            end
            s.frame_done = (out_row == 0) && (column == cw - 1);
            owed_samples.push_back(s);
         end
         column++;
         if (column >= sw) begin
            column = 0;
            source_row++;
            if (source_row >= sh) source_row = 0;
         end
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_sample(yuv_sample_type got);
         yuv_sample_type want;
         if (owed_samples.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual luma %0d at index %0d",
                     $time, got.luma, got.luma_index);
            return;
         end
         want = owed_samples.pop_front();
         compare_field("luma", want.luma, got.luma);
         compare_field("luma_index", want.luma_index, got.luma_index);
         compare_field("chroma_valid", want.chroma_valid, got.chroma_valid);
         compare_field("chroma_u", want.chroma_u, got.chroma_u);
         compare_field("chroma_v", want.chroma_v, got.chroma_v);
         compare_field("chroma_index", want.chroma_index, got.chroma_index);
         compare_field("frame_done", want.frame_done, got.frame_done);
      endfunction
   endclass

   // All inputs of the block start at known values.
   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    csr_valid       = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index       = '0;
   logic [CFG_W-1:0]        csr_data        = '0;
   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic [PIX_W-1:0]        req_red         = '0;
   logic [PIX_W-1:0]        req_green       = '0;
   logic [PIX_W-1:0]        req_blue        = '0;
   logic                    req_frame_start = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   logic [PIX_W-1:0]        rsp_luma;
   logic [LUMA_IDX_W-1:0]   rsp_luma_index;
   logic                    rsp_chroma_valid;
   logic [PIX_W-1:0]        rsp_chroma_u;
   logic [PIX_W-1:0]        rsp_chroma_v;
   logic [CHROMA_IDX_W-1:0] rsp_chroma_index;
   logic                    rsp_frame_done;

   yuv_plane_tracker planes = new();

   // Idle pattern, in percent of cycles, for each side of the block.
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   int unsigned hold_cycles   = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned random_pixels = 0;
   int unsigned colour_pick   = 0;

   rgba_to_yuv420_flip_crop u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_luma         (rsp_luma),
      .rsp_luma_index   (rsp_luma_index),
      .rsp_chroma_valid (rsp_chroma_valid),
      .rsp_chroma_u     (rsp_chroma_u),
      .rsp_chroma_v     (rsp_chroma_v),
      .rsp_chroma_index (rsp_chroma_index),
      .rsp_frame_done   (rsp_frame_done)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Every handshake is observed here at the rising edge. All drivers use
   // nonblocking assignments, so the values read are those from before the
   // edge whatever the order in which the processes wake.
   always @(posedge clock) begin : observe
      yuv_sample_type seen;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            planes.write_reg(csr_index, csr_data);
         end
         if (req_valid && req_ready) begin
            planes.note_pixel(req_red, req_green, req_blue, req_frame_start);
         end
         if (rsp_valid && rsp_ready) begin
            seen.luma         = rsp_luma;
            seen.luma_index   = rsp_luma_index;
            seen.chroma_valid = rsp_chroma_valid;
            seen.chroma_u     = rsp_chroma_u;
            seen.chroma_v     = rsp_chroma_v;
            seen.chroma_index = rsp_chroma_index;
            seen.frame_done   = rsp_frame_done;
            planes.check_sample(seen);
         end
      end
   end

   // The run is declared hung when nothing at all is accepted for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: stalls at random at the current rate, or holds off for a long
   // counted stretch when the stimulus asks for one.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_ready   <= 1'b0;
            hold_cycles  = hold_cycles - 1;
         end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Picks one of the four idle patterns: none, sender only, receiver only
   // or both sides.
   task automatic pick_idle_mode();
      case ($urandom_range(3))
         0: begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            req_idle_pct  = 53;
            rsp_stall_pct = 0;
         end
         2: begin
            req_idle_pct  = 0;
            rsp_stall_pct = 53;
         end
         default: begin
            req_idle_pct  = 28;
            rsp_stall_pct = 28;
         end
      endcase
   endtask

   // Writes all four frame registers back to back. Only called while the
   // block is idle, so the new geometry applies from the next pixel on.
   task automatic program_frame(input int unsigned sw, input int unsigned sh,
                                input int unsigned cw, input int unsigned ch);
      logic [CSR_IDX_W-1:0] regs [4];
      int unsigned          vals [4];
      regs = '{CSR_SOURCE_WIDTH, CSR_SOURCE_HEIGHT, CSR_CROP_WIDTH, CSR_CROP_HEIGHT};
      vals = '{sw, sh, cw, ch};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= CFG_W'(vals[i]);
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Offers one pixel, after a random idle stretch when the sender is set to
   // idle, and returns at the edge at which the item is accepted. Valid stays
   // high into the next call unless that call idles first.
   task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b, input logic frame_start);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stops offering pixels and waits until every owed sample has arrived,
   // then lets the pipeline empty of pixels that give no item.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (planes.owed() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Short directed burst with the corner colours; the first pixel marks a
   // new frame.
   task automatic directed_burst(input int unsigned count);
      logic [23:0] c;
      for (int i = 0; i < count; i++) begin
         c = CORNER_COLOURS[colour_pick % 16];
         colour_pick++;
         send_pixel(c[23:16], c[15:8], c[7:0], i == 0);
      end
      wait_drained();
   endtask

   // Component value that lands on either limit now and then.
   function automatic logic [PIX_W-1:0] pick_component();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // One random segment: a new frame geometry, then mostly whole frames with
   // a start mark on their first pixel. Now and then the mark is missing or a
   // stray one cuts a frame short.
   task automatic random_segment();
      int unsigned sw, sh, cw, ch, frame_len, count, pos;
      logic        frame_start;
      case ($urandom_range(9))
         0, 1, 2: begin
            sw = $urandom_range(16, 24);
            sh = $urandom_range(16, 20);
            cw = 16;
            ch = 16;
         end
         3: begin
            sw = $urandom_range(32, 34);
            sh = $urandom_range(16, 17);
            cw = 32;
            ch = 16;
         end
         4, 5: begin
            // Tiny frames with odd, zero or oversized crops.
            sw = $urandom_range(1, 9);
            sh = $urandom_range(1, 9);
            cw = $urandom_range(0, 12);
            ch = $urandom_range(0, 12);
         end
         6: begin
            // Zero or near-zero source sizes with a crop that must saturate.
            sw = $urandom_range(0, 3);
            sh = $urandom_range(0, 3);
            cw = 16;
            ch = 16;
         end
         7: begin
            sw = $urandom_range(2, 8);
            sh = $urandom_range(2, 8);
            cw = $urandom_range(1, sw);
            ch = sh;
         end
         8: begin
            // Raw register values; a full-height crop keeps the first row in.
            sw = $urandom_range(0, 4095);
            sh = $urandom_range(0, 4095);
            cw = $urandom_range(0, 4095);
            ch = 4095;
         end
         default: begin
            sw = $urandom_range(16, 20);
            sh = $urandom_range(17, 30);
            cw = 16;
            ch = 16;
         end
      endcase
      program_frame(sw, sh, cw, ch);
      frame_len = yuv_plane_tracker::effective_dim(sw) *
                  yuv_plane_tracker::effective_dim(sh);
      if (frame_len <= 600) begin
         count = $urandom_range(frame_len / 2 + 1, frame_len + 32);
         if (count < 20) count = 20;
      end else begin
         count = $urandom_range(30, 120);
      end
      // The last segment is cut to the remaining budget of random pixels.
      if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;
      pos = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) pick_idle_mode();
         if (pos == 0) begin
            frame_start = ($urandom_range(9) != 0);
         end else begin
            frame_start = ($urandom_range(49) == 0);
         end
         if (frame_start) pos = 0;
         send_pixel(pick_component(), pick_component(), pick_component(), frame_start);
         pos = (pos + 1 == frame_len) ? 0 : pos + 1;
      end
      random_pixels += count;
      wait_drained();
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first pixels run with the reset geometry, which
      // checks the register defaults; after that come a crop larger than
      // the source, zero source sizes, an odd crop that is not a multiple
      // of sixteen, sizes above the maximum written as all ones, and a zero
      // crop that keeps nothing.
      directed_burst(3);
      program_frame(4, 2, 16, 16);
      directed_burst(8);
      program_frame(0, 0, 16, 16);
      directed_burst(2);
      program_frame(3, 3, 3, 2);
      directed_burst(9);
      program_frame(4095, 4095, 4095, 4095);
      directed_burst(3);
      program_frame(16, 16, 0, 0);
      directed_burst(3);

      // Back-pressure: the receiver holds off for a long stretch while the
      // sender keeps offering pixels of a fully kept frame, so the block
      // fills and stalls its input. The drain afterwards is the pause in
      // which the sender waits for every owed item.
      program_frame(16, 16, 16, 16);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_cycles   = HOLD_OFF_CYCLES;
      for (int i = 0; i < 64; i++) begin
         send_pixel(pick_component(), pick_component(), pick_component(), i == 0);
      end
      wait_drained();

      while (random_pixels < RANDOM_PIXELS) random_segment();

      if (planes.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/r2y_pkg.sv
rtl/core/rgba_to_yuv420_flip_crop.sv
tb/sv/rgba_to_yuv420_flip_crop_tb.sv
